/* src/assert_macros.svh */
// assertion macros used by the glyph_outline_dilation rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property a implies b on the same edge
`define ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// property a implies b on the next edge
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

/* src/gld_pkg.sv */
// types, constants and tables for the glyph outline dilation block
// no dependencies
package gld_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int BRUSH_RADIUS  = 3;
   localparam int WIN           = 2 * BRUSH_RADIUS + 1;
   localparam int STORE_ROWS    = 2 * BRUSH_RADIUS;
   localparam int HEIGHT_LIMIT  = 1024;
   localparam int CFG_BITS      = 11;
   localparam int CSR_IDX_BITS  = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   typedef struct packed {
      logic       kind;
      logic [7:0] coverage;
   } req_word_type;

   typedef struct packed {
      logic [7:0] glyph_level;
      logic [7:0] outline_level;
      logic       last_pixel;
   } rsp_word_type;

   typedef logic [7:0] gamma_table_type [256];
   typedef logic [8:0] brush_type [WIN][WIN];

   localparam brush_type BRUSH = '{
      '{9'd10, 9'd30,  9'd45,  9'd50,  9'd45,  9'd30,  9'd10},
      '{9'd30, 9'd65,  9'd85,  9'd100, 9'd85,  9'd65,  9'd30},
      '{9'd45, 9'd85,  9'd200, 9'd256, 9'd200, 9'd85,  9'd45},
      '{9'd50, 9'd100, 9'd256, 9'd256, 9'd256, 9'd100, 9'd50},
      '{9'd45, 9'd85,  9'd200, 9'd256, 9'd200, 9'd85,  9'd45},
      '{9'd30, 9'd65,  9'd85,  9'd100, 9'd85,  9'd65,  9'd30},
      '{9'd10, 9'd30,  9'd45,  9'd50,  9'd45,  9'd30,  9'd10}
   };

   // largest g with g^4 <= 255 * v^3, built at elaboration
   function automatic gamma_table_type gamma_table();
      gamma_table_type t;
      longint unsigned target;
      longint unsigned m;
      for (int v = 0; v < 256; v++) begin
         target = 64'(255) * 64'(v) * 64'(v) * 64'(v);
         t[v] = 8'd0;
         for (int g = 0; g < 256; g++) begin
            m = 64'(g);
            if (m * m * m * m <= target) begin
               t[v] = 8'(g);
            end
         end
      end
      return t;
   endfunction

   localparam gamma_table_type GAMMA = gamma_table();

endpackage

/* src/glyph_outline_dilation.sv */
// Each accepted word passes stages a, b and c to its registered result, once
// the window lag of 3 rows plus 3 pixels has filled; one word a cycle unless
// stalled. The pipeline advances whenever the result register is empty or
// taken; the input is held off in a cycle where a register write is offered.
// Synchronous reset clears positions, counters, window and valid bits; the
// line store is not cleared, its unwritten reads are masked by row position.
module glyph_outline_dilation #(
   parameter int MAX_WIDTH = gld_pkg::MAX_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  gld_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output gld_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gld_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [gld_pkg::CFG_BITS-1:0]        csr_data
);
   `include "assert_macros.svh"

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int W   = gld_pkg::WIN;
   localparam int SR  = gld_pkg::STORE_ROWS;
   localparam int R   = gld_pkg::BRUSH_RADIUS;
   localparam int WB  = gld_pkg::CFG_BITS;

   typedef struct packed {
      logic         emit;
      logic         last;
      logic [W-1:0] colmask;
   } ctrl_type;

   logic [WB-1:0]  image_width_ff, image_height_ff;
   logic [CW-1:0]  in_col_ff, emit_col_ff;
   logic [WB-1:0]  in_row_ff;
   logic [2:0]     row_mod_ff;
   logic [21:0]    k_ff;
   logic [20:0]    emitted_ff, frame_total;
   logic [13:0]    frame_lag;
   logic [WB-1:0]  w_eff, h_eff;

   logic           adv, accept;
   logic [7:0]     v_gamma;
   logic [SR-1:0]  rowok;
   logic           center_ok;
   ctrl_type       ctrl_now;

   logic           a_valid_ff;
   ctrl_type       a_ctrl_ff;
   logic [SR-1:0]  a_rowok_ff;
   logic [2:0]     a_rmod_ff;
   logic [7:0]     a_v_ff;
   logic [7:0]     rd_data [SR];

   logic [7:0]     window_ff [W][W];
   logic [7:0]     column [W];
   logic           b_valid_ff;
   ctrl_type       b_ctrl_ff;

   logic           c_valid_ff;
   ctrl_type       c_ctrl_ff;
   logic [8:0]     c_rowmax_ff [W];
   logic [8:0]     c_rowmax_in [W];
   logic [7:0]     c_g_ff;

   logic           rsp_valid_ff;
   gld_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && !csr_valid;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // effective frame size
   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = WB'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         w_eff = WB'(MAX_WIDTH);
      end else begin
         w_eff = image_width_ff;
      end
      if (image_height_ff == '0) begin
         h_eff = WB'(1);
      end else if (32'(image_height_ff) > gld_pkg::HEIGHT_LIMIT) begin
         h_eff = WB'(gld_pkg::HEIGHT_LIMIT);
      end else begin
         h_eff = image_height_ff;
      end
   end

   assign frame_total = 21'(h_eff) * 21'(w_eff);
   assign frame_lag   = 14'(w_eff) * 14'd3 + 14'd3;

   assign v_gamma   = req_word.kind ? 8'd0 : gld_pkg::GAMMA[req_word.coverage];
   assign center_ok = in_row_ff < h_eff;

   always_comb begin
      logic signed [CW+2:0] cc;
      for (int i = 0; i < SR; i++) begin
         rowok[i] = (in_row_ff >= WB'(SR - i)) &&
                    ((in_row_ff - WB'(SR - i)) < h_eff);
      end
      for (int j = 0; j < W; j++) begin
         cc = $signed({3'b000, emit_col_ff}) + (CW+3)'(j - R);
         ctrl_now.colmask[j] = (cc >= 0) && (cc < $signed({2'b00, w_eff}));
      end
      ctrl_now.emit = (k_ff >= 22'(frame_lag)) && (emitted_ff < frame_total);
      ctrl_now.last = (emitted_ff + 21'd1) == frame_total;
   end

   // position and frame counters
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WB'(64);
         image_height_ff <= WB'(64);
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         row_mod_ff      <= '0;
         k_ff            <= '0;
         emitted_ff      <= '0;
         emit_col_ff     <= '0;
      end else if (csr_valid && (csr_index == gld_pkg::CSR_IMAGE_WIDTH ||
                                 csr_index == gld_pkg::CSR_IMAGE_HEIGHT)) begin
         if (csr_index == gld_pkg::CSR_IMAGE_WIDTH) begin
            image_width_ff <= csr_data;
         end else begin
            image_height_ff <= csr_data;
         end
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         row_mod_ff  <= '0;
         k_ff        <= '0;
         emitted_ff  <= '0;
         emit_col_ff <= '0;
      end else if (accept) begin
         if (ctrl_now.emit && ctrl_now.last) begin
            in_col_ff   <= '0;
            in_row_ff   <= '0;
            row_mod_ff  <= '0;
            k_ff        <= '0;
            emitted_ff  <= '0;
            emit_col_ff <= '0;
         end else begin
            k_ff <= k_ff + 22'd1;
            if ({1'b0, in_col_ff} + (CW+1)'(1) >= (CW+1)'(w_eff)) begin
               in_col_ff  <= '0;
               in_row_ff  <= in_row_ff + WB'(1);
               row_mod_ff <= (row_mod_ff == 3'(SR - 1)) ? 3'd0 : row_mod_ff + 3'd1;
            end else begin
               in_col_ff <= in_col_ff + CW'(1);
            end
            if (ctrl_now.emit) begin
               emitted_ff <= emitted_ff + 21'd1;
               if ({1'b0, emit_col_ff} + (CW+1)'(1) >= (CW+1)'(w_eff)) begin
                  emit_col_ff <= '0;
               end else begin
                  emit_col_ff <= emit_col_ff + CW'(1);
               end
            end
         end
      end
   end

   // line store banks, one per stored row
   for (genvar bk = 0; bk < SR; bk++) begin : g_bank
      gld_line_bank #(.DEPTH(MAX_WIDTH)) u_bank (
         .clock   (clock),
         .wr_en   (accept && row_mod_ff == 3'(bk)),
         .wr_addr (in_col_ff),
         .wr_data (center_ok ? v_gamma : 8'd0),
         .rd_en   (accept),
         .rd_addr (in_col_ff),
         .rd_data (rd_data[bk])
      );
   end

   // column assembly from rotated banks
   always_comb begin
      logic [3:0] bsel;
      for (int i = 0; i < SR; i++) begin
         bsel = 4'(a_rmod_ff) + 4'(i);
         if (bsel >= 4'(SR)) begin
            bsel = bsel - 4'(SR);
         end
         column[i] = a_rowok_ff[i] ? rd_data[bsel[2:0]] : 8'd0;
      end
      column[SR] = a_v_ff;
   end

   // weighted row maxima
   always_comb begin
      logic [16:0] p;
      for (int i = 0; i < W; i++) begin
         c_rowmax_in[i] = 9'd0;
         for (int j = 0; j < W; j++) begin
            p = 17'(window_ff[i][j]) * 17'(gld_pkg::BRUSH[i][j]);
            if (b_ctrl_ff.colmask[j] && p[16:8] > c_rowmax_in[i]) begin
               c_rowmax_in[i] = p[16:8];
            end
         end
      end
   end

   always_comb begin
      logic [8:0] best;
      logic [9:0] sum;
      best = 9'd0;
      for (int i = 0; i < W; i++) begin
         if (c_rowmax_ff[i] > best) begin
            best = c_rowmax_ff[i];
         end
      end
      sum = 10'(best) + 10'(c_g_ff);
      rsp_word_in.glyph_level   = c_g_ff;
      rsp_word_in.outline_level = (sum > 10'd255) ? 8'd255 : sum[7:0];
      rsp_word_in.last_pixel    = c_ctrl_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < W; i++) begin
            for (int j = 0; j < W; j++) begin
               window_ff[i][j] <= 8'd0;
            end
         end
      end else if (adv) begin
         a_valid_ff   <= accept;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         rsp_valid_ff <= c_valid_ff && c_ctrl_ff.emit;
         if (a_valid_ff) begin
            for (int i = 0; i < W; i++) begin
               for (int j = 0; j < W - 1; j++) begin
                  window_ff[i][j] <= window_ff[i][j+1];
               end
               window_ff[i][W-1] <= column[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ctrl_ff   <= ctrl_now;
         a_rowok_ff  <= rowok;
         a_rmod_ff   <= row_mod_ff;
         a_v_ff      <= center_ok ? v_gamma : 8'd0;
         b_ctrl_ff   <= a_ctrl_ff;
         c_ctrl_ff   <= b_ctrl_ff;
         c_rowmax_ff <= c_rowmax_in;
         c_g_ff      <= window_ff[R][R];
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `ASSERT_IMPLY(a_row_mod_range, clock, reset, 1'b1, row_mod_ff < 3'(SR))
   `ASSERT_IMPLY(a_emit_bound, clock, reset, 1'b1, emitted_ff <= frame_total)
   `ASSERT_NEXT(a_frame_restart, clock, reset,
      accept && ctrl_now.emit && ctrl_now.last, k_ff == 22'd0 && emitted_ff == 21'd0)
   `ASSERT_NEXT(a_rsp_from_emit, clock, reset,
      adv && !(c_valid_ff && c_ctrl_ff.emit), !rsp_valid_ff)

endmodule

/* src/gld_line_bank.sv */
// one row of the line store: single write port, registered read port
// depends on nothing
module gld_line_bank #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/glyph_outline_dilation_tb.sv */
// testbench for glyph_outline_dilation: streams coverage frames, predicts the
// glyph and dilated outline bytes per pixel and checks them in order
// depends on gld_pkg and the glyph_outline_dilation rtl
module glyph_outline_dilation_tb;

   class outline_scoreboard;
      bit [7:0] line_rows [gld_pkg::STORE_ROWS*1024];
      bit [7:0] win [gld_pkg::WIN][gld_pkg::WIN];
      int unsigned col_pos, row_pos, emitted, width_reg, height_reg;
      gld_pkg::rsp_word_type pending_q [$];
      int errors;

      function new();
         width_reg = 64;
         height_reg = 64;
      endfunction

      task report(string s);
         $display("mismatch: %s", s);
         errors++;
      endtask

      function int unsigned clip(int unsigned x);
         return (x == 0) ? 1 : ((x > 1024) ? 1024 : x);
      endfunction

      function bit [7:0] gamma_of(int unsigned v);
         longint unsigned lim;
         lim = 255 * longint'(v) * v * v;
         for (int g = 255; g > 0; g--) begin
            if (longint'(g) * g * g * g <= lim) return 8'(g);
         end
         return 8'd0;
      endfunction

      function int unsigned weight(int i, int j);
         int di, dj;
         di = (i > 3) ? 6 - i : i;
         dj = (j > 3) ? 6 - j : j;
         if (di > dj) begin
            int t; t = di; di = dj; dj = t;
         end
         case ({di[1:0], dj[1:0]})
            4'b0000: return 10;
            4'b0001: return 30;
            4'b0010: return 45;
            4'b0011: return 50;
            4'b0101: return 65;
            4'b0110: return 85;
            4'b0111: return 100;
            4'b1010: return 200;
            default: return 256;
         endcase
      endfunction

      function void write_reg(logic [gld_pkg::CSR_IDX_BITS-1:0] idx,
                              logic [gld_pkg::CFG_BITS-1:0] d);
         if (idx == gld_pkg::CSR_IMAGE_WIDTH) width_reg = 32'(d);
         else if (idx == gld_pkg::CSR_IMAGE_HEIGHT) height_reg = 32'(d);
         else return;
         col_pos = 0;
         row_pos = 0;
         emitted = 0;
      endfunction

      function void note_word(gld_pkg::req_word_type rq);
         int unsigned w, h, ir, ic, v, k, c, best, p, s, total;
         bit [7:0] column [gld_pkg::WIN];
         bit ok;
         gld_pkg::rsp_word_type r;
         w = clip(width_reg);
         h = clip(height_reg);
         ir = row_pos;
         ic = col_pos;
         v = rq.kind ? 0 : 32'(gamma_of(32'(rq.coverage)));
         if (ic >= w) ic = w - 1;
         for (int i = 0; i < gld_pkg::STORE_ROWS; i++) begin
            ok = (ir >= gld_pkg::STORE_ROWS - i) && (ir - (gld_pkg::STORE_ROWS - i) < h);
            column[i] = ok ? line_rows[((ir + i) % gld_pkg::STORE_ROWS) * 1024 + ic] : 8'd0;
         end
         column[gld_pkg::STORE_ROWS] = (ir < h) ? 8'(v) : 8'd0;
         line_rows[(ir % gld_pkg::STORE_ROWS) * 1024 + ic] = column[gld_pkg::STORE_ROWS];
         for (int i = 0; i < gld_pkg::WIN; i++) begin
            for (int j = 0; j < gld_pkg::WIN - 1; j++) win[i][j] = win[i][j+1];
            win[i][gld_pkg::WIN-1] = column[i];
         end
         k = ir * w + ic;
         total = h * w;
         if (k >= gld_pkg::BRUSH_RADIUS * w + gld_pkg::BRUSH_RADIUS && emitted < total) begin
            c = emitted % w;
            best = 0;
            for (int i = 0; i < gld_pkg::WIN; i++) begin
               for (int j = 0; j < gld_pkg::WIN; j++) begin
                  int cc;
                  cc = int'(c) - gld_pkg::BRUSH_RADIUS + j;
                  if (cc < 0 || cc >= int'(w)) continue;
                  p = win[i][j] * weight(i, j);
                  if (p > best) best = p;
               end
            end
            s = (best >> 8) + win[3][3];
            emitted++;
            r.glyph_level = win[3][3];
            r.outline_level = (s > 255) ? 8'd255 : s[7:0];
            r.last_pixel = (emitted == total);
            pending_q.push_back(r);
            if (r.last_pixel) begin
               col_pos = 0;
               row_pos = 0;
               emitted = 0;
               return;
            end
         end
         ic++;
         if (ic >= w) begin
            ic = 0;
            ir++;
         end
         col_pos = ic & 10'h3ff;
         row_pos = ir & 11'h7ff;
      endfunction

      task check_word(gld_pkg::rsp_word_type got);
         gld_pkg::rsp_word_type e;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected word %h", got));
            return;
         end
         e = pending_q.pop_front();
         if (got.glyph_level != e.glyph_level)
            report($sformatf("glyph_level %0d want %0d", got.glyph_level, e.glyph_level));
         if (got.outline_level != e.outline_level)
            report($sformatf("outline_level %0d want %0d", got.outline_level,
                             e.outline_level));
         if (got.last_pixel != e.last_pixel)
            report($sformatf("last_pixel %0d want %0d", got.last_pixel, e.last_pixel));
      endtask
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   gld_pkg::req_word_type req_word;
   gld_pkg::rsp_word_type rsp_word;
   logic [gld_pkg::CSR_IDX_BITS-1:0] csr_index;
   logic [gld_pkg::CFG_BITS-1:0] csr_data;
   outline_scoreboard sb;
   bit quiet;
   int sent;

   glyph_outline_dilation dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && req_ready) sb.note_word(req_word);
         if (rsp_valid && rsp_ready) sb.check_word(rsp_word);
      end
   end

   initial begin
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_ready <= 1;
      end
   end

   task send_word(logic kind, logic [7:0] cov);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1;
      req_word <= '{kind: kind, coverage: cov};
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task drain();
      req_valid <= 0;
      do @(posedge clock); while (sb.pending_q.size() != 0);
      repeat (12) @(posedge clock);
   endtask

   task write_csr(logic [gld_pkg::CSR_IDX_BITS-1:0] idx, logic [gld_pkg::CFG_BITS-1:0] d);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task set_frame(int unsigned w, int unsigned h);
      write_csr(gld_pkg::CSR_IMAGE_WIDTH, gld_pkg::CFG_BITS'(w));
      write_csr(gld_pkg::CSR_IMAGE_HEIGHT, gld_pkg::CFG_BITS'(h));
   endtask

   // one well-formed frame plus its tail, with some noise items
   task run_frame(int unsigned noise);
      int unsigned w, h;
      w = sb.clip(sb.width_reg);
      h = sb.clip(sb.height_reg);
      for (int unsigned i = 0; i < w * h; i++) begin
         if ($urandom_range(0, 99) < noise) send_word(1, 8'($urandom));
         else send_word(0, 8'($urandom));
      end
      for (int unsigned i = 0; i < 3 * w + 3; i++) begin
         if ($urandom_range(0, 99) < noise) send_word(0, 8'($urandom));
         else send_word(1, 8'($urandom));
      end
   endtask

   initial begin
      int unsigned n;
      sb = new();
      quiet = 0;
      sent = 0;
      reset = 1;
      req_valid = 0;
      req_word = '0;
      csr_valid = 0;
      csr_index = '0;
      csr_data = '0;
      repeat (7) @(posedge clock);
      reset <= 0;

      // default 64x64 frame, abandoned part way
      repeat (250) send_word(0, 8'($urandom));
      drain();

      set_frame(1, 1);
      send_word(0, 8'hff);
      repeat (6) send_word(1, 8'h00);
      drain();
      set_frame(7, 3);
      send_word(0, 8'h00);
      send_word(0, 8'hff);
      send_word(0, 8'h01);
      send_word(0, 8'h80);
      send_word(1, 8'hff);
      repeat (16) send_word(0, 8'hff);
      repeat (24) send_word(0, 8'h7f);
      drain();
      write_csr(2'd2, 11'h7ff);
      write_csr(2'd3, 11'h000);
      set_frame(0, 0);
      run_frame(20);
      drain();
      // oversized frames, abandoned part way
      set_frame(11'h7ff, 1);
      repeat (60) send_word(0, 8'($urandom));
      drain();
      set_frame(1, 11'h7ff);
      repeat (120) send_word(1'($urandom), 8'($urandom));
      drain();

      while (sent < 1000) begin
         if ($urandom_range(0, 9) == 0) set_frame($urandom_range(0, 2), $urandom_range(0, 2));
         else set_frame($urandom_range(1, 12), $urandom_range(1, 9));
         if ($urandom_range(0, 5) == 0)
            write_csr(gld_pkg::CSR_IDX_BITS'($urandom_range(2, 3)),
                      gld_pkg::CFG_BITS'($urandom));
         n = $urandom_range(1, 3);
         for (int f = 0; f < n; f++) run_frame($urandom_range(0, 1) ? 0 : 10);
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 40)) send_word(1'($urandom), 8'($urandom));
         if (sent > 850) quiet = 1;
         drain();
      end

      drain();
      if (sb.pending_q.size() != 0) sb.report("results left over");
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
